// ===== rtl/l3t_pkg.sv =====
// Shared widths, request codes and interpolation arithmetic for the 3D color table.
`timescale 1ns / 1ps
`default_nettype none
package l3t_pkg;

   localparam int DATA_W = 16;
   localparam int FRAC_W = 12;
   localparam int IDX_W  = 16;
   localparam int CSR_W  = 6;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef logic signed [DATA_W-1:0] color_type;
   typedef logic [FRAC_W-1:0] frac_type;

   // a + floor((b - a) * f / 4096), saturated to the 16-bit range.
   function automatic color_type lerp(input color_type a, input color_type b,
                                      input frac_type f);
      logic signed [DATA_W:0]          diff;
      logic signed [DATA_W+FRAC_W+1:0] prod;
      logic signed [DATA_W+2:0]        total;
      color_type                       result;
      diff  = (DATA_W+1)'(b) - (DATA_W+1)'(a);
      prod  = diff * $signed({1'b0, f});
      total = (DATA_W+3)'(a) + (DATA_W+3)'(prod >>> FRAC_W);
      if (total > (DATA_W+3)'(32767)) begin
         result = 16'sh7fff;
      end else if (total < -(DATA_W+3)'(32768)) begin
         result = 16'sh8000;
      end else begin
         result = total[DATA_W-1:0];
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/l3t_if.sv =====
// Valid/ready channel interfaces for requests, results and the size register.
`timescale 1ns / 1ps
`default_nettype none
interface l3t_req_if;
   import l3t_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [IDX_W-1:0]         entry_index;
   logic signed [DATA_W-1:0] entry_red;
   logic signed [DATA_W-1:0] entry_green;
   logic signed [DATA_W-1:0] entry_blue;
   logic signed [DATA_W-1:0] pix_red;
   logic signed [DATA_W-1:0] pix_green;
   logic signed [DATA_W-1:0] pix_blue;
   logic signed [DATA_W-1:0] pix_alpha;
   modport source (output valid, req_type, entry_index, entry_red, entry_green, entry_blue,
                   pix_red, pix_green, pix_blue, pix_alpha, input ready);
   modport sink (input valid, req_type, entry_index, entry_red, entry_green, entry_blue,
                 pix_red, pix_green, pix_blue, pix_alpha, output ready);
endinterface

interface l3t_rsp_if;
   import l3t_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_red;
   logic signed [DATA_W-1:0] out_green;
   logic signed [DATA_W-1:0] out_blue;
   logic signed [DATA_W-1:0] out_alpha;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface l3t_csr_if;
   import l3t_pkg::*;
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] lut_size;
   modport source (output valid, lut_size, input ready);
   modport sink (input valid, lut_size, output ready);
endinterface
`default_nettype wire

// ===== rtl/l3t_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module l3t_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/lut3d_trilinear_color_map.sv =====
// Top level of the trilinear 3D color lookup table pipeline.
// Takes one beat per clock, table writes and pixel lookups alike, and returns
// each lookup's result from the output register after the interpolation stages; writes return nothing.
// The table is held as eight identical RAM copies of MAX_LUT_SIZE^3 entries,
// one per cube corner, so that all eight corners are read in the same cycle;
// every write goes to all copies. Writes take effect in the same pipeline
// stage where lookups read, so order between writes and lookups is kept.
// The whole pipeline holds while a finished result waits and is not taken.
// A new table size must be written while no lookup is in flight.
`timescale 1ns / 1ps
`default_nettype none
module lut3d_trilinear_color_map #(
   parameter int MAX_LUT_SIZE = 33
) (
   input  logic      clock,
   input  logic      reset,
   l3t_req_if.sink   req_bus,
   l3t_rsp_if.source rsp_bus,
   l3t_csr_if.sink   csr_bus
);
   import l3t_pkg::*;

   localparam int SW    = $clog2(MAX_LUT_SIZE + 1);
   localparam int IW    = $clog2(MAX_LUT_SIZE);
   localparam int DEPTH = MAX_LUT_SIZE * MAX_LUT_SIZE * MAX_LUT_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = DATA_W + SW + 1;
   localparam int CW    = PW - FRAC_W + 1;
   localparam int RW    = 3 * DATA_W;

   // Size register and its square.
   logic [SW-1:0]   size_ff, size_in;
   logic [2*SW-1:0] sq_ff;
   logic            csr_we;

   assign csr_bus.ready = 1'b1;
   assign csr_we = csr_bus.valid && csr_bus.ready;

   always_comb begin
      if (32'(csr_bus.lut_size) > MAX_LUT_SIZE) begin
         size_in = SW'(MAX_LUT_SIZE);
      end else begin
         size_in = SW'(csr_bus.lut_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         sq_ff   <= '0;
      end else begin
         if (csr_we) begin
            size_ff <= size_in;
         end
         sq_ff <= (2*SW)'((2*SW)'(size_ff) * (2*SW)'(size_ff));
      end
   end

   logic adv;
   logic req_take;
   logic vo_ff;

   assign adv          = !vo_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign req_take     = req_bus.valid && adv;

   // Stage 1: scale each channel by the table size.
   logic                s1_valid_ff, s1_lookup_ff, s1_pass_ff;
   logic [IDX_W-1:0]    s1_index_ff;
   logic [RW-1:0]       s1_entry_ff;
   logic signed [PW-1:0] s1_scaled_ff [3];
   color_type           s1_pix_ff [3];
   color_type           s1_alpha_ff;
   color_type           pix_in [3];

   assign pix_in[0] = req_bus.pix_red;
   assign pix_in[1] = req_bus.pix_green;
   assign pix_in[2] = req_bus.pix_blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (adv) begin
         s1_lookup_ff <= (req_bus.req_type == REQ_LOOKUP);
         s1_pass_ff   <= (size_ff == '0);
         s1_index_ff  <= req_bus.entry_index;
         s1_entry_ff  <= {req_bus.entry_blue, req_bus.entry_green, req_bus.entry_red};
         s1_alpha_ff  <= req_bus.pix_alpha;
         for (int c = 0; c < 3; c++) begin
            s1_pix_ff[c]    <= pix_in[c];
            s1_scaled_ff[c] <= PW'(pix_in[c] * $signed({1'b0, size_ff}));
         end
      end
   end

   // Stage 2: floor index, fraction, and clamped corner indices.
   logic                s2_valid_ff, s2_lookup_ff, s2_pass_ff;
   logic [IDX_W-1:0]    s2_index_ff;
   logic [RW-1:0]       s2_entry_ff;
   logic [IW-1:0]       s2_lo_ff [3], s2_hi_ff [3], s2_lo_in [3], s2_hi_in [3];
   frac_type            s2_fr_ff [3];
   color_type           s2_pix_ff [3];
   color_type           s2_alpha_ff;

   always_comb begin
      logic signed [CW-1:0] fl, flp, szm;
      szm = $signed(CW'(size_ff)) - CW'(1);
      for (int c = 0; c < 3; c++) begin
         fl  = CW'(s1_scaled_ff[c] >>> FRAC_W);
         flp = fl + CW'(1);
         if (fl < 0) begin
            s2_lo_in[c] = '0;
         end else if (fl > szm) begin
            s2_lo_in[c] = IW'(szm);
         end else begin
            s2_lo_in[c] = IW'(fl);
         end
         if (flp < 0) begin
            s2_hi_in[c] = '0;
         end else if (flp > szm) begin
            s2_hi_in[c] = IW'(szm);
         end else begin
            s2_hi_in[c] = IW'(flp);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_lookup_ff <= s1_lookup_ff;
         s2_pass_ff   <= s1_pass_ff;
         s2_index_ff  <= s1_index_ff;
         s2_entry_ff  <= s1_entry_ff;
         s2_alpha_ff  <= s1_alpha_ff;
         for (int c = 0; c < 3; c++) begin
            s2_pix_ff[c] <= s1_pix_ff[c];
            s2_lo_ff[c]  <= s2_lo_in[c];
            s2_hi_ff[c]  <= s2_hi_in[c];
            s2_fr_ff[c]  <= s1_scaled_ff[c][FRAC_W-1:0];
         end
      end
   end

   // Stage 3: green and blue row offsets; addresses and table writes leave here.
   logic                s3_valid_ff, s3_lookup_ff, s3_pass_ff;
   logic [IDX_W-1:0]    s3_index_ff;
   logic [RW-1:0]       s3_entry_ff;
   logic [IW-1:0]       s3_xlo_ff, s3_xhi_ff;
   logic [AW-1:0]       s3_yoff_ff [2], s3_zoff_ff [2];
   frac_type            s3_fr_ff [3];
   color_type           s3_pix_ff [3];
   color_type           s3_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s3_lookup_ff  <= s2_lookup_ff;
         s3_pass_ff    <= s2_pass_ff;
         s3_index_ff   <= s2_index_ff;
         s3_entry_ff   <= s2_entry_ff;
         s3_alpha_ff   <= s2_alpha_ff;
         s3_xlo_ff     <= s2_lo_ff[0];
         s3_xhi_ff     <= s2_hi_ff[0];
         s3_yoff_ff[0] <= AW'(AW'(s2_lo_ff[1]) * AW'(size_ff));
         s3_yoff_ff[1] <= AW'(AW'(s2_hi_ff[1]) * AW'(size_ff));
         s3_zoff_ff[0] <= AW'(AW'(s2_lo_ff[2]) * AW'(sq_ff));
         s3_zoff_ff[1] <= AW'(AW'(s2_hi_ff[2]) * AW'(sq_ff));
         for (int c = 0; c < 3; c++) begin
            s3_pix_ff[c] <= s2_pix_ff[c];
            s3_fr_ff[c]  <= s2_fr_ff[c];
         end
      end
   end

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr [8];
   logic [RW-1:0] ram_rdata [8];

   assign ram_we    = adv && s3_valid_ff && (s3_lookup_ff == REQ_WRITE)
                      && (32'(s3_index_ff) < DEPTH);
   assign ram_waddr = AW'(s3_index_ff);

   // Corner n has red in bit 0, green in bit 1 and blue in bit 2.
   for (genvar n = 0; n < 8; n++) begin : g_corner
      assign ram_raddr[n] = AW'((n % 2 == 1) ? s3_xhi_ff : s3_xlo_ff)
                            + s3_yoff_ff[(n / 2) % 2] + s3_zoff_ff[n / 4];
      l3t_ram #(
         .WIDTH (RW),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (ram_waddr),
         .wr_data (s3_entry_ff),
         .rd_en   (adv),
         .rd_addr (ram_raddr[n]),
         .rd_data (ram_rdata[n])
      );
   end

   // Stage 4: corner data arrives from the RAMs alongside these registers.
   logic      s4_valid_ff, s4_pass_ff;
   frac_type  s4_fr_ff [3];
   color_type s4_pix_ff [3];
   color_type s4_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff && (s3_lookup_ff == REQ_LOOKUP);
      end
      if (adv) begin
         s4_pass_ff  <= s3_pass_ff;
         s4_alpha_ff <= s3_alpha_ff;
         for (int c = 0; c < 3; c++) begin
            s4_pix_ff[c] <= s3_pix_ff[c];
            s4_fr_ff[c]  <= s3_fr_ff[c];
         end
      end
   end

   // Stage 5: interpolate along red.
   logic      s5_valid_ff, s5_pass_ff;
   frac_type  s5_fry_ff, s5_frz_ff;
   color_type s5_pix_ff [3];
   color_type s5_alpha_ff;
   color_type s5_row_ff [3][2][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (adv) begin
         s5_pass_ff  <= s4_pass_ff;
         s5_alpha_ff <= s4_alpha_ff;
         s5_fry_ff   <= s4_fr_ff[1];
         s5_frz_ff   <= s4_fr_ff[2];
         for (int c = 0; c < 3; c++) begin
            s5_pix_ff[c] <= s4_pix_ff[c];
            for (int z = 0; z < 2; z++) begin
               for (int y = 0; y < 2; y++) begin
                  s5_row_ff[c][z][y] <= lerp(
                     ram_rdata[z*4 + y*2][c*DATA_W +: DATA_W],
                     ram_rdata[z*4 + y*2 + 1][c*DATA_W +: DATA_W],
                     s4_fr_ff[0]);
               end
            end
         end
      end
   end

   // Stage 6: interpolate along green.
   logic      s6_valid_ff, s6_pass_ff;
   frac_type  s6_frz_ff;
   color_type s6_pix_ff [3];
   color_type s6_alpha_ff;
   color_type s6_plane_ff [3][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (adv) begin
         s6_pass_ff  <= s5_pass_ff;
         s6_alpha_ff <= s5_alpha_ff;
         s6_frz_ff   <= s5_frz_ff;
         for (int c = 0; c < 3; c++) begin
            s6_pix_ff[c] <= s5_pix_ff[c];
            for (int z = 0; z < 2; z++) begin
               s6_plane_ff[c][z] <= lerp(s5_row_ff[c][z][0], s5_row_ff[c][z][1], s5_fry_ff);
            end
         end
      end
   end

   // Output register: interpolate along blue, or pass the pixel when size is zero.
   color_type out_ff [3];
   color_type out_in [3];
   color_type out_alpha_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (s6_pass_ff) begin
            out_in[c] = s6_pix_ff[c];
         end else begin
            out_in[c] = lerp(s6_plane_ff[c][0], s6_plane_ff[c][1], s6_frz_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= s6_valid_ff;
      end
      if (adv) begin
         out_alpha_ff <= s6_alpha_ff;
         for (int c = 0; c < 3; c++) begin
            out_ff[c] <= out_in[c];
         end
      end
   end

   assign rsp_bus.valid     = vo_ff;
   assign rsp_bus.out_red   = out_ff[0];
   assign rsp_bus.out_green = out_ff[1];
   assign rsp_bus.out_blue  = out_ff[2];
   assign rsp_bus.out_alpha = out_alpha_ff;

   // The clamped size never exceeds the table edge.
   assert property (@(posedge clock) disable iff (reset) size_ff <= SW'(MAX_LUT_SIZE))
      else $error("table size register above maximum");

   // The stored square, registered from the size, matches it unless a size write was just taken.
   assert property (@(posedge clock) disable iff (reset)
      !$past(csr_we) |-> sq_ff == (2*SW)'((2*SW)'(size_ff) * (2*SW)'(size_ff)))
      else $error("size square out of step with size");

   // A result appears only after a lookup left the last interpolation stage.
   assert property (@(posedge clock) disable iff (reset) $rose(vo_ff) |-> $past(s6_valid_ff))
      else $error("result beat without a lookup behind it");

endmodule
`default_nettype wire

// ===== test/tb_lut3d_trilinear_color_map.sv =====
// Testbench for the trilinear 3D color lookup table: random table loads and lookups, scoreboarded.
`timescale 1ns / 1ps
module tb_lut3d_trilinear_color_map;
   import l3t_pkg::*;

   localparam int TABLE_EDGE  = 33;
   localparam int TABLE_DEPTH = TABLE_EDGE * TABLE_EDGE * TABLE_EDGE;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic             kind;
      logic [IDX_W-1:0] index;
      color_type        entry[3];
      color_type        pix[3];
      color_type        alpha;
   } color_req_s;

   typedef struct {
      color_type rgb[3];
      color_type alpha;
   } color_rsp_s;

   class color_map_scoreboard;
      color_type  cube[3][TABLE_DEPTH];
      bit         loaded[TABLE_DEPTH];
      int         lut_size;
      int         mismatches;
      color_rsp_s pending[$];

      function new();
         lut_size = 0;
         mismatches = 0;
      endfunction

      function int edge_len();
         return (lut_size > TABLE_EDGE) ? TABLE_EDGE : lut_size;
      endfunction

      // Floor index, clamped neighbor pair and 12-bit fraction along one axis.
      function void axis_span(input color_type p, input int n, output int lo, output int hi,
                              output int fr);
         longint s;
         longint fl;
         s  = longint'(p) * n;
         fl = s >>> FRAC_W;
         fr = int'(s - fl * 4096);
         lo = (fl < 0) ? 0 : (fl > n - 1) ? n - 1 : int'(fl);
         hi = (fl + 1 < 0) ? 0 : (fl + 1 > n - 1) ? n - 1 : int'(fl + 1);
      endfunction

      function color_type blend(input color_type a, input color_type b, input int f);
         longint v;
         v = longint'(a) + (((longint'(b) - longint'(a)) * f) >>> FRAC_W);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return 16'sh8000;
         return color_type'(v);
      endfunction

      function bit corners_loaded(input color_type px[3]);
         int n;
         int lo[3], hi[3], fr[3];
         n = edge_len();
         for (int c = 0; c < 3; c++) axis_span(px[c], n, lo[c], hi[c], fr[c]);
         for (int k = 0; k < 8; k++) begin
            if (!loaded[(k[0] ? hi[0] : lo[0]) + (k[1] ? hi[1] : lo[1]) * n
                        + (k[2] ? hi[2] : lo[2]) * n * n]) return 0;
         end
         return 1;
      endfunction

      function void note_request(input color_req_s r);
         color_rsp_s e;
         int n;
         int lo[3], hi[3], fr[3];
         color_type row[2], plane[2];
         int x, y, z;
         if (r.kind == REQ_WRITE) begin
            if (r.index < TABLE_DEPTH) begin
               for (int c = 0; c < 3; c++) cube[c][r.index] = r.entry[c];
               loaded[r.index] = 1;
            end
            return;
         end
         n = edge_len();
         e.alpha = r.alpha;
         if (n == 0) begin
            e.rgb = r.pix;
         end else begin
            for (int c = 0; c < 3; c++) axis_span(r.pix[c], n, lo[c], hi[c], fr[c]);
            for (int c = 0; c < 3; c++) begin
               for (int kz = 0; kz < 2; kz++) begin
                  z = kz ? hi[2] : lo[2];
                  for (int jy = 0; jy < 2; jy++) begin
                     y = jy ? hi[1] : lo[1];
                     x = y * n + z * n * n;
                     row[jy] = blend(cube[c][x + lo[0]], cube[c][x + hi[0]], fr[0]);
                  end
                  plane[kz] = blend(row[0], row[1], fr[1]);
               end
               e.rgb[c] = blend(plane[0], plane[1], fr[2]);
            end
         end
         pending.push_back(e);
      endfunction

      task report(input string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(input color_rsp_s got);
         color_rsp_s e;
         if (pending.size() == 0) begin
            report("result beat with no lookup outstanding");
            return;
         end
         e = pending.pop_front();
         for (int c = 0; c < 3; c++) begin
            if (got.rgb[c] !== e.rgb[c])
               report($sformatf("channel %0d got %0d expected %0d", c, got.rgb[c], e.rgb[c]));
         end
         if (got.alpha !== e.alpha)
            report($sformatf("alpha got %0d expected %0d", got.alpha, e.alpha));
      endtask
   endclass

   logic clock;
   logic reset;
   l3t_req_if req_bus();
   l3t_rsp_if rsp_bus();
   l3t_csr_if csr_bus();

   lut3d_trilinear_color_map #(.MAX_LUT_SIZE(TABLE_EDGE)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   color_map_scoreboard colors;
   bit quiet;
   int cycles;
   int ready_hold;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_WRITE;
      req_bus.entry_index = '0;
      req_bus.entry_red = '0;
      req_bus.entry_green = '0;
      req_bus.entry_blue = '0;
      req_bus.pix_red = '0;
      req_bus.pix_green = '0;
      req_bus.pix_blue = '0;
      req_bus.pix_alpha = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.lut_size = '0;
      colors = new();
      quiet = 0;
      cycles = 0;
      ready_hold = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_lut3d_trilinear_color_map NOT OK");
         $finish;
      end
   end

   // Result side stalls in short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = $urandom_range(0, 5);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      color_rsp_s got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.rgb[0] = rsp_bus.out_red;
         got.rgb[1] = rsp_bus.out_green;
         got.rgb[2] = rsp_bus.out_blue;
         got.alpha = rsp_bus.out_alpha;
         colors.check_result(got);
      end
   end

   task send_beat(input color_req_s r);
      req_bus.valid <= 1'b1;
      req_bus.req_type <= r.kind;
      req_bus.entry_index <= r.index;
      req_bus.entry_red <= r.entry[0];
      req_bus.entry_green <= r.entry[1];
      req_bus.entry_blue <= r.entry[2];
      req_bus.pix_red <= r.pix[0];
      req_bus.pix_green <= r.pix[1];
      req_bus.pix_blue <= r.pix[2];
      req_bus.pix_alpha <= r.alpha;
      do @(posedge clock); while (!req_bus.ready);
      colors.note_request(r);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task drain_results();
      while (colors.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task set_lut_size(input int n);
      req_bus.valid <= 1'b0;
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.lut_size <= CSR_W'(n);
      do @(posedge clock); while (!csr_bus.ready);
      colors.lut_size = n;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function color_type any_color();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return color_type'($urandom());
      endcase
   endfunction

   task write_entry(input int addr, input color_type r, input color_type g, input color_type b);
      color_req_s q;
      q.kind = REQ_WRITE;
      q.index = IDX_W'(addr);
      q.entry[0] = r;
      q.entry[1] = g;
      q.entry[2] = b;
      for (int c = 0; c < 3; c++) q.pix[c] = color_type'($urandom());
      q.alpha = color_type'($urandom());
      send_beat(q);
   endtask

   task lookup(input color_type r, input color_type g, input color_type b, input color_type a);
      color_req_s q;
      q.kind = REQ_LOOKUP;
      q.index = IDX_W'($urandom());
      for (int c = 0; c < 3; c++) q.entry[c] = color_type'($urandom());
      q.pix[0] = r;
      q.pix[1] = g;
      q.pix[2] = b;
      q.alpha = a;
      send_beat(q);
   endtask

   // Loads the whole cube for small edges; for larger edges, only the
   // cells next to the low and high faces, which lookups are then kept to.
   task load_cube(input int n);
      int m;
      int axis[$];
      m = (n > TABLE_EDGE) ? TABLE_EDGE : n;
      axis.delete();
      if (m <= 6) begin
         for (int i = 0; i < m; i++) axis.push_back(i);
      end else begin
         axis = '{0, 1, 2, m - 3, m - 2, m - 1};
      end
      foreach (axis[b]) foreach (axis[g]) foreach (axis[r])
         write_entry(axis[r] + axis[g] * m + axis[b] * m * m,
                     any_color(), any_color(), any_color());
   endtask

   function color_type pick_channel();
      case ($urandom_range(0, 3))
         0: return color_type'($urandom());
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return color_type'(int'($urandom_range(0, 4700)) - 300);
      endcase
   endfunction

   task random_phase(input int n, input int count);
      color_type px[3];
      int m;
      m = (n > TABLE_EDGE) ? TABLE_EDGE : n;
      set_lut_size(n);
      load_cube(n);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0: write_entry($urandom_range(TABLE_DEPTH, 65535),
                           any_color(), any_color(), any_color());
            1, 2: begin
               // Rewrite an entry that lookups may already read.
               int addr;
               do addr = $urandom_range(0, TABLE_DEPTH - 1);
               while (!colors.loaded[addr]);
               write_entry(addr, any_color(), any_color(), any_color());
            end
            default: begin
               do begin
                  for (int c = 0; c < 3; c++) px[c] = pick_channel();
               end while (m != 0 && !colors.corners_loaded(px));
               lookup(px[0], px[1], px[2], color_type'($urandom()));
            end
         endcase
      end
   endtask

   initial begin
      int plan[$];
      plan = '{1, 3, 33, 5, 63, 2, 6, 4, 34, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pass-through, writes at size zero and writes past the end of the table.
      lookup(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh8000);
      lookup(16'sh8000, 16'sh7fff, 16'sh1000, 16'sh7fff);
      write_entry(65535, 16'sh7fff, 16'sh8000, 16'sh7fff);
      write_entry(TABLE_DEPTH, 16'sh8000, 16'sh7fff, 16'sh8000);
      write_entry(0, 16'sh7fff, 16'sh8000, 16'sh0000);

      // Size two cube with extreme entries, probed at its corners and beyond.
      set_lut_size(2);
      for (int a = 0; a < 8; a++)
         write_entry(a, a[0] ? 16'sh7fff : 16'sh8000, a[1] ? 16'sh7fff : 16'sh8000,
                     a[2] ? 16'sh8000 : 16'sh7fff);
      lookup(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      lookup(16'sh0800, 16'sh0800, 16'sh0800, 16'sh1234);
      lookup(16'sh07ff, 16'sh0001, 16'sh0fff, -16'sd1);
      lookup(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      lookup(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      lookup(16'sh1000, 16'sh8000, 16'sh7fff, 16'sh5555);

      // Hold off until the pipeline is empty before the random part.
      req_bus.valid <= 1'b0;
      drain_results();

      foreach (plan[p]) begin
         if (p == plan.size() - 2) quiet = 1;
         random_phase(plan[p], 45);
      end

      req_bus.valid <= 1'b0;
      drain_results();
      if (colors.mismatches == 0) begin
         $display("tb_lut3d_trilinear_color_map OK");
      end else begin
         $display("tb_lut3d_trilinear_color_map NOT OK");
      end
      $finish;
   end

endmodule
